// ===== hdl/drs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package drs_pkg;

	localparam int MAX_RECORDS_DEF = 64;

	// member order is the sort key order, so the packed word compares directly
	typedef struct packed {
		logic        no_date;
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [15:0] record_id;
	} record_t;

	// chain-wide control, same for every cell
	typedef struct packed {
		logic ins;  // insert the broadcast record
		logic shl;  // shift the chain one cell toward the head
	} ctrl_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	// true when a must go strictly after b
	function automatic logic rec_after(input record_t a, input record_t b);
		return a > b;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/drs_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module drs_cell (
	input  wire              clk,
	input  drs_pkg::ctrl_t   ctrl,
	input  drs_pkg::record_t in_rec,
	input  drs_pkg::record_t left_rec,
	input  drs_pkg::record_t right_rec,
	input  wire              occ,
	input  wire              left_occ,
	input  wire              left_after,
	output drs_pkg::record_t rec,
	output logic             after
);

	drs_pkg::record_t rec_q;
	logic             load;

	assign after = occ && drs_pkg::rec_after(rec_q, in_rec);
	// displaced cells and the first free cell take a new value
	assign load  = ctrl.ins && (after || (!occ && left_occ));
	assign rec   = rec_q;

	always_ff @(posedge clk) begin
		if (ctrl.shl) begin
			rec_q <= right_rec;
		end else if (load) begin
			rec_q <= left_after ? left_rec : in_rec;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/date_record_sorter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  handshake            payload
// in       input      in_valid / in_stall  record_id no_date year month day is_final
// out      output     out_valid / out_stall out_record_id out_no_date out_year
//                                          out_month out_day out_last
//
// one record per cycle while loading: every cell compares against the
// broadcast record and the chain shifts to make room for it
// after the final record, the batch drains from the head cell, one transfer
// per cycle unless out_stall is high, while in_stall is held high
// reset clears the fill count and the state; cell contents are not reset
// out_stall only holds the head cell and the drain; loading ignores it
// records arriving on a full chain are dropped, a final one still drains

module date_record_sorter_core #(
	parameter int MAX_RECORDS = drs_pkg::MAX_RECORDS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [15:0] record_id,
	input  wire         no_date,
	input  wire  [13:0] year,
	input  wire  [3:0]  month,
	input  wire  [4:0]  day,
	input  wire         is_final,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] out_record_id,
	output logic        out_no_date,
	output logic [13:0] out_year,
	output logic [3:0]  out_month,
	output logic [4:0]  out_day,
	output logic        out_last
);

	localparam int CW = $clog2(MAX_RECORDS + 1);

	drs_pkg::state_t  state_q, state_nx;
	logic [CW-1:0]    count_q;
	drs_pkg::ctrl_t   ctrl;
	drs_pkg::record_t in_rec;
	drs_pkg::record_t rec_w [MAX_RECORDS];
	logic             after_w [MAX_RECORDS];
	logic             occ_w [MAX_RECORDS];
	logic             in_xfer, out_xfer, full;

	assign in_rec = '{no_date: no_date, year: year, month: month, day: day,
		record_id: record_id};

	assign full     = (count_q == CW'(MAX_RECORDS));
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			drs_pkg::ST_LOAD: begin
				if (in_xfer && is_final) state_nx = drs_pkg::ST_DRAIN;
			end
			drs_pkg::ST_DRAIN: begin
				if (out_xfer && out_last) state_nx = drs_pkg::ST_LOAD;
			end
			default: state_nx = drs_pkg::ST_LOAD;
		endcase
	end

	// outputs of the controller
	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			drs_pkg::ST_LOAD:  in_stall  = 1'b0;
			drs_pkg::ST_DRAIN: out_valid = 1'b1;
			default: ;
		endcase
	end

	// a full chain drops the record but still honors is_final
	assign ctrl.ins = in_xfer && !full;
	assign ctrl.shl = out_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= drs_pkg::ST_LOAD;
			count_q <= '0;
		end else begin
			state_q <= state_nx;
			if (ctrl.ins) begin
				count_q <= count_q + CW'(1);
			end else if (ctrl.shl) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// the chain: cell 0 is the head and holds the smallest record
	for (genvar i = 0; i < MAX_RECORDS; i++) begin : g_cell
		drs_pkg::record_t left_rec, right_rec;
		logic             left_occ, left_after;

		assign occ_w[i] = (count_q > CW'(i));

		if (i == 0) begin : g_head
			assign left_rec   = in_rec;
			assign left_occ   = 1'b1;
			assign left_after = 1'b0;
		end else begin : g_body
			assign left_rec   = rec_w[i-1];
			assign left_occ   = occ_w[i-1];
			assign left_after = after_w[i-1];
		end

		if (i == MAX_RECORDS - 1) begin : g_tail
			// value is past the fill count after a shift, never read
			assign right_rec = rec_w[i];
		end else begin : g_inner
			assign right_rec = rec_w[i+1];
		end

		drs_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.in_rec     (in_rec),
			.left_rec   (left_rec),
			.right_rec  (right_rec),
			.occ        (occ_w[i]),
			.left_occ   (left_occ),
			.left_after (left_after),
			.rec        (rec_w[i]),
			.after      (after_w[i])
		);
	end

	// head cell is the output register
	assign out_record_id = rec_w[0].record_id;
	assign out_no_date   = rec_w[0].no_date;
	assign out_year      = rec_w[0].year;
	assign out_month     = rec_w[0].month;
	assign out_day       = rec_w[0].day;
	assign out_last      = (count_q == CW'(1));

	// a drain always has at least one record to send
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == drs_pkg::ST_DRAIN |-> count_q != '0)
		else $error("drain with empty chain");

	// the closing transfer leaves an empty chain ready to load
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && out_last |=> state_q == drs_pkg::ST_LOAD && count_q == '0)
		else $error("chain not empty after last transfer");

	// no insert and shift together, and no insert beyond capacity
	a_ins_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |-> !ctrl.shl && count_q < CW'(MAX_RECORDS))
		else $error("bad insert");

	// an accepted final record starts the drain
	a_final_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && is_final |=> state_q == drs_pkg::ST_DRAIN)
		else $error("final record did not start drain");

endmodule

`default_nettype wire

// ===== dv/date_record_sorter_core_tb.sv =====
`timescale 1ns / 1ps

module date_record_sorter_core_tb;

	localparam int CHAIN_DEPTH = drs_pkg::MAX_RECORDS_DEF;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 16;
	localparam int PRINT_CAP = 50;

	typedef struct {
		drs_pkg::record_t rec;
		bit               last;
	} sorted_out_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [15:0] record_id;
	logic        no_date;
	logic [13:0] year;
	logic [3:0]  month;
	logic [4:0]  day;
	logic        is_final;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] out_record_id;
	logic        out_no_date;
	logic [13:0] out_year;
	logic [3:0]  out_month;
	logic [4:0]  out_day;
	logic        out_last;

	// predicted chain contents, kept in sorted order
	drs_pkg::record_t chain_model[$];
	// sorted records still to come out of the block
	sorted_out_t      sorted_out_q[$];

	bit          idle_on = 1'b1;
	int          mismatch_count = 0;
	int          cycle_count = 0;
	int          out_hold = 0;
	sorted_out_t want;

	date_record_sorter_core #(
		.MAX_RECORDS(CHAIN_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.record_id    (record_id),
		.no_date      (no_date),
		.year         (year),
		.month        (month),
		.day          (day),
		.is_final     (is_final),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_record_id(out_record_id),
		.out_no_date  (out_no_date),
		.out_year     (out_year),
		.out_month    (out_month),
		.out_day      (out_day),
		.out_last     (out_last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// true when a sorts strictly after b: undated last, then date, then id
	function automatic bit sorts_later(input drs_pkg::record_t a, input drs_pkg::record_t b);
		if (a.no_date != b.no_date)
			return a.no_date > b.no_date;
		if (a.year != b.year)
			return a.year > b.year;
		if (a.month != b.month)
			return a.month > b.month;
		if (a.day != b.day)
			return a.day > b.day;
		return a.record_id > b.record_id;
	endfunction

	// insert behind every entry that does not sort later, so equal keys keep arrival order
	function automatic void absorb_record(input drs_pkg::record_t r, input bit fin);
		int pos;
		sorted_out_t item;
		if (chain_model.size() < CHAIN_DEPTH) begin
			pos = chain_model.size();
			while (pos > 0 && sorts_later(chain_model[pos - 1], r))
				pos--;
			chain_model.insert(pos, r);
		end
		if (fin) begin
			foreach (chain_model[k]) begin
				item.rec  = chain_model[k];
				item.last = (k == chain_model.size() - 1);
				sorted_out_q.push_back(item);
			end
			chain_model.delete();
		end
	endfunction

	function automatic int draw_wait();
		if (!idle_on)
			return 0;
		if ($urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	function automatic drs_pkg::record_t make_record(input int id, input bit nd, input int yr,
		input int mo, input int dy);
		drs_pkg::record_t r;
		r.record_id = id[15:0];
		r.no_date   = nd;
		r.year      = yr[13:0];
		r.month     = mo[3:0];
		r.day       = dy[4:0];
		return r;
	endfunction

	// narrow draws pile up ties on every key
	function automatic drs_pkg::record_t rand_record(input bit narrow);
		if (narrow)
			return make_record($urandom_range(0, 7), $urandom_range(0, 1),
				$urandom_range(2000, 2001), $urandom_range(1, 2), $urandom_range(1, 2));
		return make_record($urandom_range(0, 65535), $urandom_range(0, 3) == 0,
			$urandom_range(0, 16383), $urandom_range(0, 15), $urandom_range(0, 31));
	endfunction

	task automatic report_mismatch(input string what, input int got, input int exp_val);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch at cycle %0d: %s got %0d expected %0d",
				cycle_count, what, got, exp_val);
	endtask

	task automatic send_record(input drs_pkg::record_t r, input bit fin);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		record_id <= r.record_id;
		no_date   <= r.no_date;
		year      <= r.year;
		month     <= r.month;
		day       <= r.day;
		is_final  <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		absorb_record(r, fin);
	endtask

	task automatic send_batch(input int n, input bit narrow);
		for (int i = 0; i < n; i++)
			send_record(rand_record(narrow), i == n - 1);
	endtask

	// hold the sender off until the block has emitted everything predicted
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sorted_out_q.size() != 0)
			@(posedge clk);
	endtask

	// output side: random stall after each transfer, sometimes also while idle
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			out_hold  <= draw_wait();
			out_stall <= idle_on && ($urandom_range(0, 3) != 0);
		end else if (out_hold > 1) begin
			out_hold <= out_hold - 1;
		end else if (out_hold == 1) begin
			out_hold  <= 0;
			out_stall <= 1'b0;
		end else if (out_stall) begin
			out_stall <= 1'b0;
		end else if (!out_valid && idle_on && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			out_hold  <= $urandom_range(1, 15);
		end
	end

	// compare every transfer on the output with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (sorted_out_q.size() == 0) begin
				report_mismatch("unexpected result, record_id", out_record_id, -1);
			end else begin
				want = sorted_out_q.pop_front();
				if (out_record_id !== want.rec.record_id)
					report_mismatch("out_record_id", out_record_id, want.rec.record_id);
				if (out_no_date !== want.rec.no_date)
					report_mismatch("out_no_date", out_no_date, want.rec.no_date);
				if (out_year !== want.rec.year)
					report_mismatch("out_year", out_year, want.rec.year);
				if (out_month !== want.rec.month)
					report_mismatch("out_month", out_month, want.rec.month);
				if (out_day !== want.rec.day)
					report_mismatch("out_day", out_day, want.rec.day);
				if (out_last !== want.last)
					report_mismatch("out_last", out_last, want.last);
			end
		end
	end

	// a batch of one record with every field at its top value
	task automatic test_lone_final();
		send_record(make_record(65535, 1, 16383, 15, 31), 1'b1);
	endtask

	// each key level decides in turn; undated pairs still compare by date
	task automatic test_key_order();
		send_record(make_record(5, 0, 2020, 6, 15), 1'b0);
		send_record(make_record(4, 0, 2020, 6, 15), 1'b0);
		send_record(make_record(9, 1, 0, 0, 0), 1'b0);
		send_record(make_record(3, 1, 9999, 12, 31), 1'b0);
		send_record(make_record(0, 0, 0, 0, 0), 1'b0);
		send_record(make_record(7, 0, 16383, 15, 31), 1'b0);
		send_record(make_record(8, 0, 9999, 13, 0), 1'b0);
		send_record(make_record(2, 0, 2020, 6, 14), 1'b0);
		send_record(make_record(1, 0, 2020, 5, 31), 1'b0);
		send_record(make_record(6, 0, 2019, 12, 31), 1'b0);
		send_record(make_record(4, 0, 2020, 6, 15), 1'b0);
		send_record(make_record(65535, 1, 16383, 15, 31), 1'b0);
		send_record(make_record(10, 1, 0, 0, 0), 1'b0);
		send_record(make_record(11, 0, 1, 1, 1), 1'b1);
	endtask

	// arrivals in descending order force a shift on every insert after the first
	task automatic test_reverse_order();
		for (int i = 0; i < 6; i++)
			send_record(make_record(100 - i, 0, 3000 - i, 12 - i, 31 - i), i == 5);
	endtask

	task automatic test_random_batches();
		repeat (40) begin
			idle_on = ($urandom_range(0, 3) != 0);
			send_batch($urandom_range(1, 12), $urandom_range(0, 2) == 0);
		end
		idle_on = 1'b1;
	endtask

	// exact fill, a final dropped on a full chain, and overflow before the final
	task automatic test_full_chain();
		idle_on = 1'b0;
		send_batch(CHAIN_DEPTH, 1'b1);
		idle_on = 1'b1;
		for (int i = 0; i < CHAIN_DEPTH; i++)
			send_record(rand_record(1'b0), 1'b0);
		send_record(rand_record(1'b0), 1'b1);
		send_batch(CHAIN_DEPTH + 6, 1'b0);
	endtask

	task automatic test_drain_pause();
		repeat (5) begin
			send_batch($urandom_range(1, 6), 1'b0);
			wait_drained();
		end
	endtask

	initial begin
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		record_id <= '0;
		no_date   <= 1'b0;
		year      <= '0;
		month     <= '0;
		day       <= '0;
		is_final  <= 1'b0;
		out_stall <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_lone_final();
		test_key_order();
		test_reverse_order();
		test_random_batches();
		test_full_chain();
		test_drain_pause();

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sorted_out_q.size() != 0)
			report_mismatch("results still outstanding", 0, sorted_out_q.size());
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
